// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication-style property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/hdu_pkg.sv =====
// ---------------------------------------------------------------------------
// hdu_pkg
// Types and constants of the half-duplex 8N1 serial port.
// ---------------------------------------------------------------------------
package hdu_pkg;

  // Configuration register indexes
  localparam logic CFG_BIT_TICKS   = 1'b0;
  localparam logic CFG_START_TICKS = 1'b1;

  // Register reset values
  localparam logic [15:0] RST_BIT_TICKS   = 16'd208;
  localparam logic [15:0] RST_START_TICKS = 16'd312;

  // Data bits per frame
  localparam logic [3:0] DATA_BITS = 4'd8;

  // One tick beat, first field in the highest bits
  typedef struct packed {
    logic [7:0] send_data;
    logic       send;
    logic       rx_level;
  } hdu_tick_t;

  // One result beat, first field in the highest bits
  typedef struct packed {
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       tx_level;
  } hdu_result_t;

  // Core status toward the top level
  typedef struct packed {
    logic busy;
    logic sending;
  } hdu_status_t;

endpackage

// ===== rtl/hdu_core.sv =====
// ---------------------------------------------------------------------------
// hdu_core
// Frame state and single-tick step logic for transmit and receive.
// ---------------------------------------------------------------------------
module hdu_core
  import hdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        tick_fire,
  input  hdu_tick_t   tick,
  output hdu_result_t result,
  output hdu_status_t status
);

  logic [15:0] bit_ticks;
  logic [15:0] start_ticks;

  logic        sending;
  logic        active;
  logic [3:0]  bit_count;
  logic [7:0]  shift_reg;
  logic [15:0] tick_count;
  logic        prev_rx;
  logic        line_out;

  logic        sending_next;
  logic        active_next;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_reg_next;
  logic [15:0] tick_count_next;
  logic        line_out_next;
  logic        valid_next;
  logic [7:0]  byte_next;

  logic [15:0] period_raw;
  logic [15:0] period;
  logic [15:0] tick_inc;

  // Pick the current period; a zero period acts as one tick
  assign period_raw = (!sending && bit_count == 4'd0) ? start_ticks : bit_ticks;
  assign period     = (period_raw == 16'd0) ? 16'd1 : period_raw;
  assign tick_inc   = tick_count + 16'd1;

  // Step the frame by one tick
  always_comb begin
    sending_next    = sending;
    active_next     = active;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    tick_count_next = tick_count;
    line_out_next   = line_out;
    valid_next      = 1'b0;
    byte_next       = 8'd0;
    if (tick.send) begin
      shift_reg_next  = tick.send_data;
      bit_count_next  = 4'd0;
      sending_next    = 1'b1;
      active_next     = 1'b1;
      tick_count_next = 16'd0;
      line_out_next   = 1'b0;
    end else if (active) begin
      tick_count_next = tick_inc;
      if (tick_inc >= period) begin
        tick_count_next = 16'd0;
        if (bit_count < DATA_BITS) begin
          if (sending) begin
            line_out_next = shift_reg[bit_count[2:0]];
          end else begin
            shift_reg_next[bit_count[2:0]] = shift_reg[bit_count[2:0]] | tick.rx_level;
          end
          bit_count_next = bit_count + 4'd1;
        end else begin
          if (sending) begin
            line_out_next = 1'b1;
          end else begin
            valid_next = 1'b1;
            byte_next  = shift_reg;
          end
          sending_next   = 1'b0;
          active_next    = 1'b0;
          bit_count_next = 4'd0;
        end
      end
    end else if (prev_rx && !tick.rx_level) begin
      active_next     = 1'b1;
      sending_next    = 1'b0;
      bit_count_next  = 4'd0;
      shift_reg_next  = 8'd0;
      tick_count_next = 16'd0;
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks   <= RST_BIT_TICKS;
      start_ticks <= RST_START_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIT_TICKS:   bit_ticks   <= cfg_data;
        CFG_START_TICKS: start_ticks <= cfg_data;
        default:         bit_ticks   <= bit_ticks;
      endcase
    end
  end

  // Advance frame state on each accepted tick beat
  always_ff @(posedge clk) begin
    if (rst) begin
      sending    <= 1'b0;
      active     <= 1'b0;
      bit_count  <= 4'd0;
      shift_reg  <= 8'd0;
      tick_count <= 16'd0;
      prev_rx    <= 1'b1;
      line_out   <= 1'b1;
    end else if (tick_fire) begin
      sending    <= sending_next;
      active     <= active_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      tick_count <= tick_count_next;
      prev_rx    <= tick.rx_level;
      line_out   <= line_out_next;
    end
  end

  assign result.tx_level = line_out_next;
  assign result.rx_valid = valid_next;
  assign result.rx_byte  = byte_next;
  assign result.busy_res = active_next;

  assign status.busy    = active;
  assign status.sending = sending;

endmodule

// ===== rtl/hdu_skid.sv =====
// ---------------------------------------------------------------------------
// hdu_skid
// Output register with a skid stage for the result stream.
// ---------------------------------------------------------------------------
module hdu_skid
  import hdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  hdu_result_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output hdu_result_t out_data
);

  logic        skid_valid;
  hdu_result_t skid_data;

  assign in_ready = !skid_valid;

  // Control: take a beat into the output or the skid stage, drain on ready
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: follow the same moves as the control
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      if (out_valid && !out_ready) begin
        skid_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end else if (out_ready && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

// ===== rtl/half_duplex_uart_8n1.sv =====
// ---------------------------------------------------------------------------
// half_duplex_uart_8n1
// Half-duplex 8N1 serial port stepped by one timer tick per input beat.
// ---------------------------------------------------------------------------
// Each input beat is one prescaled timer tick carrying the sampled receive
// line and an optional send request; each beat yields exactly one result
// beat with the transmit line level, a received-byte strobe with its byte,
// and the busy flag. One beat is taken per clock while the skid stage is
// empty; the step logic updates the frame state in the same cycle a beat
// is accepted, and the result is registered in the output register or the
// skid stage. The user writes bit_ticks and start_ticks via the cfg port
// only while the port is idle, not enforced by the block; a zero acts as 1.
module half_duplex_uart_8n1
  import hdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // tick stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] rx_level, [1] send, [9:2] send_data
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] tx_level, [1] rx_valid, [9:2] rx_byte, [10] busy_res
);

`include "assert_macros.svh"

  hdu_tick_t   tick;
  hdu_result_t step_result;
  hdu_result_t out_result;
  hdu_status_t status;
  logic        tick_fire;

  assign tick      = s_tdata[$bits(hdu_tick_t)-1:0];
  assign tick_fire = s_tvalid && s_tready;

  hdu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick_fire (tick_fire),
    .tick      (tick),
    .result    (step_result),
    .status    (status)
  );

  hdu_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (step_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {{(16 - $bits(hdu_result_t)){1'b0}}, out_result};

  // A completed byte ends the frame, so busy is already low
  `ASSERT_NEVER(a_valid_not_busy, clk, rst, m_tvalid && out_result.rx_valid && out_result.busy_res, "rx byte reported while still busy")

  // The line is high whenever the port is not busy
  `ASSERT_NEVER(a_idle_line_high, clk, rst, m_tvalid && !out_result.busy_res && !out_result.tx_level, "idle line driven low")

  // A send beat starts a transmit frame
  `ASSERT_PROP(a_send_starts, clk, rst, tick_fire && tick.send |=> status.busy && status.sending, "send did not start a frame")

endmodule

// ===== test/half_duplex_uart_8n1_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1_tb
// Self-checking testbench for the half-duplex 8N1 serial port.
// Feeds timer-tick beats (receive line level plus send requests) into the
// tick stream and checks every result beat against a cycle-free model of
// the port. Covers directed corner cases, then random well-formed frames,
// aborted frames and line noise under several bit and start timings, with
// random stalls on both streams.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1_tb
  import hdu_pkg::*;
;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 4;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;    // [0] rx_level, [1] send, [9:2] send_data
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [0] tx_level, [1] rx_valid, [9:2] rx_byte, [10] busy_res

  // Port model state and its copy of the registers
  logic [15:0] cur_bit_ticks;
  logic [15:0] cur_start_ticks;
  logic        tx_mode;
  logic        frame_on;
  logic [3:0]  bits_done;
  logic [7:0]  shifter;
  logic [15:0] ticks;
  logic        last_rx;
  logic        tx_line;

  hdu_result_t pending_results[$];
  int          ticks_fed;
  int          errors;
  int          idle_cycles;
  logic        steady;

  half_duplex_uart_8n1 uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the port model by one tick and return the line state after it
  function automatic hdu_result_t advance_port(hdu_tick_t t);
    hdu_result_t r;
    logic [15:0] period;
    r = '0;
    if (t.send) begin
      shifter   = t.send_data;
      bits_done = '0;
      tx_mode   = 1'b1;
      frame_on  = 1'b1;
      ticks     = '0;
      tx_line   = 1'b0;
    end else if (frame_on) begin
      period = (!tx_mode && bits_done == 4'd0) ? cur_start_ticks : cur_bit_ticks;
      if (period == 16'd0) period = 16'd1;
      ticks = ticks + 16'd1;
      if (ticks >= period) begin
        ticks = '0;
        if (bits_done < DATA_BITS) begin
          if (tx_mode) tx_line = shifter[bits_done[2:0]];
          else shifter = shifter | (8'(t.rx_level) << bits_done[2:0]);
          bits_done = bits_done + 4'd1;
        end else begin
          if (tx_mode) begin
            tx_line = 1'b1;
          end else begin
            r.rx_valid = 1'b1;
            r.rx_byte  = shifter;
          end
          tx_mode   = 1'b0;
          frame_on  = 1'b0;
          bits_done = '0;
        end
      end
    end else if (last_rx && !t.rx_level) begin
      // falling edge while idle: arm a reception
      frame_on  = 1'b1;
      tx_mode   = 1'b0;
      bits_done = '0;
      shifter   = '0;
      ticks     = '0;
    end
    last_rx    = t.rx_level;
    r.tx_level = tx_line;
    r.busy_res = frame_on;
    return r;
  endfunction

  // Drive one tick beat, wait for its handshake, record the expected line
  task automatic send_tick(input logic rx, input logic snd, input logic [7:0] data);
    hdu_tick_t beat;
    beat.rx_level  = rx;
    beat.send      = snd;
    beat.send_data = data;
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, beat};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(advance_port(beat));
    ticks_fed++;
    @(negedge clk);
  endtask

  // Hold the tick stream until every expected result beat has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BIT_TICKS) cur_bit_ticks = val;
    else cur_start_ticks = val;
  endtask

  // Well-formed frame on the receive line; start, data and stop bits last per ticks
  task automatic rx_frame(input logic [7:0] b, input int unsigned per);
    int cut;
    int n;
    cut = ($urandom_range(9) == 0) ? int'($urandom_range(10 * per - 1)) : -1;
    n   = 0;
    send_tick(1'b1, 1'b0, 8'($urandom));
    for (int k = 0; k < 10; k++) begin
      for (int i = 0; i < per; i++) begin
        send_tick((k == 0) ? 1'b0 : (k == 9) ? 1'b1 : b[k - 1], n == cut, 8'($urandom));
        n++;
      end
    end
    repeat ($urandom_range(3)) send_tick(1'b1, 1'b0, 8'($urandom));
  endtask

  // One transmitted frame, with stray receive blips and rare restarts
  task automatic tx_frame(input logic [7:0] b, input int unsigned per);
    send_tick(1'b1, 1'b1, b);
    repeat (9 * per + 1 + $urandom_range(2))
      send_tick($urandom_range(15) != 0, $urandom_range(199) == 0, 8'($urandom));
  endtask

  task automatic line_noise(input int unsigned n);
    repeat (n) send_tick(1'($urandom_range(1)), $urandom_range(19) == 0, 8'($urandom));
  endtask

  // Mix of frames and noise for about count ticks at the current timing
  task automatic run_phase(input int count);
    int target;
    int unsigned per;
    int unsigned pick;
    target = ticks_fed + count;
    per    = (cur_bit_ticks == 16'd0) ? 1 : cur_bit_ticks;
    while (ticks_fed < target) begin
      pick = $urandom_range(99);
      if (per > 8 || pick >= 80) line_noise($urandom_range(1, 12));
      else if (pick < 55) rx_frame(8'($urandom), per);
      else tx_frame(8'($urandom), per);
    end
  endtask

  // Reset timing: a few idle ticks and a start edge that leaves a reception open
  task automatic test_reset_defaults();
    send_tick(1'b1, 1'b0, 8'h00);
    send_tick(1'b1, 1'b0, 8'hFF);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'h55);
    send_tick(1'b1, 1'b0, 8'hAA);
  endtask

  // Zero periods written while the reception is open; they act as one tick
  task automatic test_zero_period();
    logic [7:0] b;
    b = 8'h96;
    write_reg(CFG_BIT_TICKS, 16'd0);
    write_reg(CFG_START_TICKS, 16'd0);
    for (int k = 0; k < 8; k++) send_tick(b[k], 1'b0, ~b);
    send_tick(1'b1, 1'b0, 8'h00);
  endtask

  task automatic test_send_cases();
    write_reg(CFG_BIT_TICKS, 16'd1);
    write_reg(CFG_START_TICKS, 16'd1);
    // send together with a falling edge, then a restart while busy
    send_tick(1'b0, 1'b1, 8'h00);
    send_tick(1'b1, 1'b1, 8'hFF);
    // edge in the middle of the frame is ignored
    for (int k = 0; k < 8; k++) send_tick(k != 3, 1'b0, 8'h00);
    // edge on the closing tick is ignored, the low line after it too
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b1, 1'b0, 8'h00);
    // reception cut short by a send
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b1, 1'b0, 8'h00);
    send_tick(1'b0, 1'b0, 8'h00);
    send_tick(1'b1, 1'b1, 8'h5A);
    repeat (9) send_tick(1'b1, 1'b0, 8'h00);
  endtask

  task automatic test_max_periods();
    write_reg(CFG_BIT_TICKS, 16'hFFFF);
    write_reg(CFG_START_TICKS, 16'hFFFF);
    send_tick(1'b1, 1'b1, 8'hC3);
    line_noise(20);
    send_tick(1'b1, 1'b0, 8'h00);
    line_noise(20);
  endtask

  task automatic test_random_timings();
    int bit_set[6];
    int start_set[6];
    bit_set   = '{1, 2, 3, 4, 2, 1};
    start_set = '{1, 3, 4, 6, 1, 2};
    bit_set[5]   = $urandom_range(1, 5);
    start_set[5] = $urandom_range(1, 8);
    foreach (bit_set[i]) begin
      write_reg(CFG_BIT_TICKS, 16'(bit_set[i]));
      write_reg(CFG_START_TICKS, 16'(start_set[i]));
      run_phase(240);
    end
  endtask

  // Stop feeding mid-stream until the result stream has caught up
  task automatic test_drained_pause();
    write_reg(CFG_BIT_TICKS, 16'd2);
    write_reg(CFG_START_TICKS, 16'd3);
    run_phase(100);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    run_phase(100);
  endtask

  task automatic test_steady_stream();
    write_reg(CFG_BIT_TICKS, 16'd3);
    write_reg(CFG_START_TICKS, 16'd5);
    steady = 1'b1;
    run_phase(200);
    steady = 1'b0;
  endtask

  // Random stalls on the result stream
  always @(negedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 33);
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    hdu_result_t got;
    hdu_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[10:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("tx_level", 8'(want.tx_level), 8'(got.tx_level));
        check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      end
    end
  end

  // End the run when neither stream moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[half_duplex_uart_8n1] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    steady    = 1'b0;
    ticks_fed = 0;
    errors    = 0;

    // model state after reset
    cur_bit_ticks   = RST_BIT_TICKS;
    cur_start_ticks = RST_START_TICKS;
    tx_mode   = 1'b0;
    frame_on  = 1'b0;
    bits_done = '0;
    shifter   = '0;
    ticks     = '0;
    last_rx   = 1'b1;
    tx_line   = 1'b1;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_zero_period();
    test_send_cases();
    test_max_periods();
    test_random_timings();
    test_drained_pause();
    test_steady_stream();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("[half_duplex_uart_8n1] OK");
    else $display("[half_duplex_uart_8n1] ERROR");
    $finish;
  end

endmodule
